// ===== hw/rtl/bee_pkg.sv =====
// Shared types and constants for the button edge event latch.
package bee_pkg;

  localparam int NUM_BUTTONS   = 8;
  localparam int SAMPLE_W      = 8;
  localparam int NUM_CELLS     = (NUM_BUTTONS < SAMPLE_W) ? NUM_BUTTONS : SAMPLE_W;
  localparam int BTN_IDX_W     = 3;
  localparam int TIME_W        = 32;
  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd100000;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TAKE   = 1'b1
  } op_t;

  typedef enum logic {
    KIND_DOWN = 1'b0,
    KIND_UP   = 1'b1
  } kind_t;

  // Control broadcast to every cell.
  typedef struct packed {
    logic accept;
    op_t  op;
    logic expire;
  } cell_ctl_t;

  // Ripple chain between neighboring cells.
  typedef struct packed {
    logic taken;  // an earlier cell already claimed the event
    logic any;    // some earlier latch is set
  } chain_t;

  // One result transaction.
  typedef struct packed {
    logic                 pending;
    logic                 event_valid;
    logic [BTN_IDX_W-1:0] button_index;
    kind_t                event_kind;
  } result_t;

endpackage

// ===== hw/rtl/bee_cell.sv =====
// One button cell: reported state, press latch and release latch.
module bee_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  bee_pkg::cell_ctl_t ctl,
  input  logic              now,
  input  bee_pkg::chain_t   chain_in,
  output bee_pkg::chain_t   chain_out,
  output logic              hit,
  output bee_pkg::kind_t    kind
);
  import bee_pkg::*;

  logic rep_r, press_r, rel_r;
  logic rep_nxt, press_nxt, rel_nxt;
  logic p0, q0, p1, q1, p2, q2, dn, up;

  always_comb begin
    p0 = (ctl.op == OP_TAKE && ctl.expire) ? 1'b0 : press_r;
    q0 = (ctl.op == OP_TAKE && ctl.expire) ? 1'b0 : rel_r;
    p1 = p0 | (now & ~rep_r);
    q1 = q0 | (~now & rep_r);
    // drop latch combinations that cannot produce an event
    q2 = q1 & (p1 | rep_r);
    p2 = p1 & (q2 | ~rep_r);
    dn = p2 & ~rep_r;
    up = q2 & rep_r;
    hit  = 1'b0;
    kind = dn ? KIND_DOWN : KIND_UP;
    rep_nxt   = rep_r;
    press_nxt = press_r;
    rel_nxt   = rel_r;
    chain_out.any   = chain_in.any | p1 | q1;
    chain_out.taken = chain_in.taken;
    if (ctl.op == OP_SAMPLE) begin
      press_nxt = p1;
      rel_nxt   = q1;
    end else begin
      press_nxt = p2;
      rel_nxt   = q2;
      chain_out.taken = chain_in.taken | dn | up;
      if (!chain_in.taken && dn) begin
        hit       = 1'b1;
        press_nxt = 1'b0;
        rep_nxt   = 1'b1;
      end else if (!chain_in.taken && up) begin
        hit     = 1'b1;
        rel_nxt = 1'b0;
        rep_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_r   <= 1'b0;
      press_r <= 1'b0;
      rel_r   <= 1'b0;
    end else if (ctl.accept) begin
      rep_r   <= rep_nxt;
      press_r <= press_nxt;
      rel_r   <= rel_nxt;
    end
  end

endmodule

// ===== hw/rtl/bee_out_buf.sv =====
// Two-entry output buffer (output register plus skid) for result transactions.
module bee_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  input  bee_pkg::result_t  wr_data,
  output logic              full,
  output logic              rd_valid,
  input  logic              rd_stall,
  output bee_pkg::result_t  rd_data
);
  import bee_pkg::*;

  logic    main_valid_r, skid_valid_r;
  result_t main_r, skid_r;
  logic    take;

  assign take     = main_valid_r & ~rd_stall;
  assign full     = skid_valid_r;
  assign rd_valid = main_valid_r;
  assign rd_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (wr_valid) begin
      if (!main_valid_r || take) begin
        main_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      main_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        main_r <= skid_r;
      end
    end else if (wr_valid) begin
      if (!main_valid_r || take) begin
        main_r <= wr_data;
      end else begin
        skid_r <= wr_data;
      end
    end
  end

endmodule

// ===== hw/rtl/button_edge_event_latch_unit.sv =====
// Button edge event latch: a row of per-button cells with a priority ripple chain.
// An accepted transaction's result is registered in the output buffer that drives out_ ports.
// Throughput: one transaction per cycle while the output buffer is not full; the cell row,
// the 32-bit elapsed-time compare and the priority ripple are all combinational.
// Reset (rst_n low, synchronous): latches, reported state and timestamp clear, timeout
// returns to 100000 us, the output buffer empties.
module button_edge_event_latch_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [bee_pkg::TIME_W-1:0]  cfg_wr_data,
  // input transactions
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_op,
  input  logic [bee_pkg::SAMPLE_W-1:0] in_buttons_now,
  input  logic [bee_pkg::TIME_W-1:0]  in_now_us,
  // result transactions
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_pending,
  output logic                        out_event_valid,
  output logic [bee_pkg::BTN_IDX_W-1:0] out_button_index,
  output logic                        out_event_kind
);
  import bee_pkg::*;

  logic [TIME_W-1:0] timeout_r;
  logic [TIME_W-1:0] last_time_r;
  logic [TIME_W-1:0] elapsed;
  logic              accept;
  logic              buf_full;
  cell_ctl_t         ctl;
  chain_t            chain [NUM_CELLS+1];
  logic [NUM_CELLS-1:0] hit;
  kind_t             kind [NUM_CELLS];
  result_t           res, out_res;

  // Stall only when both buffer entries hold results; this never looks at out_stall.
  assign in_stall = buf_full;
  assign accept   = in_valid & ~buf_full;

  // Modular elapsed time since the last sample-op timestamp.
  assign elapsed = in_now_us - last_time_r;

  assign ctl.accept = accept;
  assign ctl.op     = op_t'(in_op);
  assign ctl.expire = (elapsed > timeout_r);

  assign chain[0].taken = 1'b0;
  assign chain[0].any   = 1'b0;

  // Cell i owns button i; sample bits above the cell count are ignored.
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    bee_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .now       (in_buttons_now[i]),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .hit       (hit[i]),
      .kind      (kind[i])
    );
  end

  // At most one cell hits, so the index and kind are plain ORs over the row.
  always_comb begin
    res.pending      = (ctl.op == OP_SAMPLE) && chain[NUM_CELLS].any;
    res.event_valid  = |hit;
    res.button_index = '0;
    res.event_kind   = KIND_DOWN;
    for (int k = 0; k < NUM_CELLS; k++) begin
      if (hit[k]) begin
        res.button_index = res.button_index | BTN_IDX_W'(k);
        res.event_kind   = kind_t'(res.event_kind | kind[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RESET;
      last_time_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      // only the sample op refreshes the timestamp
      if (accept && ctl.op == OP_SAMPLE) begin
        last_time_r <= in_now_us;
      end
    end
  end

  bee_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (accept),
    .wr_data  (res),
    .full     (buf_full),
    .rd_valid (out_valid),
    .rd_stall (out_stall),
    .rd_data  (out_res)
  );

  assign out_pending      = out_res.pending;
  assign out_event_valid  = out_res.event_valid;
  assign out_button_index = out_res.button_index;
  assign out_event_kind   = out_res.event_kind;

`ifndef ASSERT_OFF
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result held");

  a_no_event_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_event_valid) |-> (out_button_index == '0 && out_event_kind == 1'b0))
    else $error("index or kind set without an event");

  a_pending_excludes_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pending) |-> !out_event_valid)
    else $error("pending and event in one result");

  a_sample_records_time: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ctl.op == OP_SAMPLE) |=> (last_time_r == $past(in_now_us)))
    else $error("sample op did not record its timestamp");
`endif

endmodule
